@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ hdl/mtce_pkg.sv @@
// Types and constants of the mono tile color expander.
package mtce_pkg;

   // request type codes
   localparam logic [1:0] REQ_DRAW       = 2'd0;
   localparam logic [1:0] REQ_REFRESH    = 2'd1;
   localparam logic [1:0] REQ_INVALIDATE = 2'd2;

   // control register indexes
   localparam logic [1:0] CSR_FG_COLOR      = 2'd0;
   localparam logic [1:0] CSR_BG_COLOR      = 2'd1;
   localparam logic [1:0] CSR_ACTIVE_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_ACTIVE_HEIGHT = 2'd3;

   // control register reset values
   localparam logic [15:0] FG_COLOR_RST      = 16'hffff;
   localparam logic [15:0] BG_COLOR_RST      = 16'h0000;
   localparam logic [10:0] ACTIVE_WIDTH_RST  = 11'd1280;
   localparam logic [9:0]  ACTIVE_HEIGHT_RST = 10'd720;

   localparam int PIX_IDX_W = 20;
   localparam int TILE_BITS = 64;

   // one tile handed to the pixel generator
   typedef struct packed {
      logic [7:0]           col;
      logic [7:0]           row;
      logic [TILE_BITS-1:0] bits;
      logic [2:0]           ncm1;   // visible columns minus one
      logic [2:0]           nrm1;   // visible rows minus one
   } tile_job_type;

   // pixel generator status toward the control stage
   typedef struct packed {
      logic ready;   // can take a tile this cycle
      logic busy;    // a tile is being expanded
   } gen_status_type;

   // control state of the top level
   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } ctl_state_type;

endpackage

@@ hdl/mtce_ram.sv @@
// Generic simple dual-port RAM with registered read (read-first).
module mtce_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 14400
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hdl/mtce_pixel_gen.sv @@
// Pixel generator: walks one tile and drives the registered result channel.
module mtce_pixel_gen #(
   parameter int NATIVE_ROW_PIXELS = 720,
   parameter int LOGICAL_COLS      = 1280
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load_valid,
   input  mtce_pkg::tile_job_type            load_job,
   input  logic [15:0]                       fg_color,
   input  logic [15:0]                       bg_color,
   output mtce_pkg::gen_status_type          status,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mtce_pkg::PIX_IDX_W-1:0]    rsp_pixel_index,
   output logic [15:0]                       rsp_pixel_color,
   output logic                              rsp_last_write
);
   import mtce_pkg::*;

   localparam logic [PIX_IDX_W-1:0] NATIVE_MUL = PIX_IDX_W'(NATIVE_ROW_PIXELS);
   localparam logic [PIX_IDX_W-1:0] LX_TOP     = PIX_IDX_W'(LOGICAL_COLS - 1);

   logic                     busy_ff, busy_in;
   tile_job_type             job_ff, job_in;
   logic [2:0]               px_ff, px_in;
   logic [2:0]               py_ff, py_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PIX_IDX_W-1:0]     idx_ff, idx_in;
   logic [15:0]              color_ff, color_in;
   logic                     last_ff, last_in;

   logic                     step;
   logic                     at_last;
   logic [10:0]              lx;
   logic [10:0]              ly;
   logic [PIX_IDX_W-1:0]     col_off;
   logic [PIX_IDX_W-1:0]     prod;

   // one pixel per cycle while the output register is free or draining
   assign step    = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign at_last = (px_ff == job_ff.ncm1) && (py_ff == job_ff.nrm1);

   // rotate into the native frame; index wraps at its width
   assign lx      = {job_ff.col, px_ff};
   assign ly      = {job_ff.row, py_ff};
   assign col_off = LX_TOP - PIX_IDX_W'(lx);
   assign prod    = col_off * NATIVE_MUL;

   always_comb begin
      busy_in      = busy_ff;
      job_in       = job_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      idx_in       = idx_ff;
      color_in     = color_ff;
      last_in      = last_ff;

      if (step) begin
         rsp_valid_in = 1'b1;
         idx_in       = prod + PIX_IDX_W'(ly);
         color_in     = job_ff.bits[{px_ff, py_ff}] ? fg_color : bg_color;
         last_in      = at_last;
         // rows inner, columns outer
         if (py_ff == job_ff.nrm1) begin
            py_in = 3'd0;
            px_in = px_ff + 3'd1;
         end else begin
            py_in = py_ff + 3'd1;
         end
         if (at_last) begin
            busy_in = 1'b0;
         end
      end

      if (load_valid) begin
         busy_in = 1'b1;
         job_in  = load_job;
         px_in   = 3'd0;
         py_in   = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      idx_ff   <= idx_in;
      color_ff <= color_in;
      last_ff  <= last_in;
   end

   assign status.ready    = !busy_ff || (step && at_last);
   assign status.busy     = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = idx_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_last_write  = last_ff;

endmodule

@@ hdl/mono_tile_color_expander.sv @@
// Top level of the mono tile color expander: shadow store and request control.
//
// Usage:
//  Requests enter on req_* (valid/stall). A draw request carries one 8x8
//  one-bit tile; refresh and invalidate set and clear the shadow-valid mark.
//  Each drawn tile yields up to 64 pixel writes on rsp_* (valid/stall), one
//  per cycle unless stalled, with rsp_last_write on the final write of the
//  tile. Tiles outside the grid, or equal to their shadow copy while the
//  shadow is valid, give no writes.
//  The first write of a tile follows the shadow read, the compare and
//  write-back, and the pixel register. Tiles are expanded one at a time
//  through the single result port; the next request is taken while the
//  current tile is being expanded, and non-draw or dropped requests do not
//  wait for the pixel generator.
//  Reset: control registers return to their defaults, then a clearing pass
//  writes zero to every shadow entry, one per cycle, MAX_TILE_COLS *
//  MAX_TILE_ROWS entries (14400 by default); req_stall is high meanwhile.
//  The user writes control registers on csr_* only while no request is in
//  flight; the block does not enforce this. When the receiver stalls, the
//  pending write holds and requests back up.
module mono_tile_color_expander #(
   parameter int MAX_TILE_COLS     = 160,
   parameter int MAX_TILE_ROWS     = 90,
   parameter int NATIVE_ROW_PIXELS = 720,
   parameter int LOGICAL_COLS      = 1280
) (
   input  logic                           clock,
   input  logic                           reset,
   // control register port
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [15:0]                    csr_data,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_type,
   input  logic [7:0]                     req_tile_col,
   input  logic [7:0]                     req_tile_row,
   input  logic [7:0]                     req_column_bits_0,
   input  logic [7:0]                     req_column_bits_1,
   input  logic [7:0]                     req_column_bits_2,
   input  logic [7:0]                     req_column_bits_3,
   input  logic [7:0]                     req_column_bits_4,
   input  logic [7:0]                     req_column_bits_5,
   input  logic [7:0]                     req_column_bits_6,
   input  logic [7:0]                     req_column_bits_7,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mtce_pkg::PIX_IDX_W-1:0] rsp_pixel_index,
   output logic [15:0]                    rsp_pixel_color,
   output logic                           rsp_last_write
);
   import mtce_pkg::*;

`include "assert_macros.svh"

   localparam int DEPTH  = MAX_TILE_COLS * MAX_TILE_ROWS;
   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

   // control registers
   logic [15:0]  fg_ff, fg_in;
   logic [15:0]  bg_ff, bg_in;
   logic [10:0]  aw_ff, aw_in;
   logic [9:0]   ah_ff, ah_in;

   // control state and clearing pass
   ctl_state_type       state_ff, state_in;
   logic [SLOT_W-1:0]   clr_ff, clr_in;

   // compare stage
   logic                b_valid_ff, b_valid_in;
   logic [1:0]          b_type_ff, b_type_in;
   logic                b_in_grid_ff, b_in_grid_in;
   logic [SLOT_W-1:0]   b_slot_ff, b_slot_in;
   tile_job_type        b_job_ff, b_job_in;
   logic                shadow_ok_ff, shadow_ok_in;

   // last shadow write, for a read issued in the same cycle
   logic                fwd_valid_ff, fwd_valid_in;
   logic [SLOT_W-1:0]   fwd_slot_ff, fwd_slot_in;
   logic [TILE_BITS-1:0] fwd_data_ff, fwd_data_in;

   // accept-side decode
   logic [11:0]         w_sum;
   logic [8:0]          w_ceil;
   logic [10:0]         h_sum;
   logic [7:0]          h_ceil;
   logic [7:0]          grid_w;
   logic [7:0]          grid_h;
   logic                a_in_grid;
   logic [15:0]         a_slot;
   logic [10:0]         rem_w;
   logic [10:0]         rem_h;
   tile_job_type        a_job;
   logic                req_accept;

   // compare-side decode
   logic [TILE_BITS-1:0] ram_rdata;
   logic [TILE_BITS-1:0] old_bits;
   logic                b_draw_go;
   logic                b_adv;
   gen_status_type      gen_status;

   // shadow RAM port signals
   logic                ram_we;
   logic [SLOT_W-1:0]   ram_waddr;
   logic [TILE_BITS-1:0] ram_wdata;
   logic [SLOT_W-1:0]   ram_raddr;

   // control register writes
   assign csr_ready = 1'b1;

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      aw_in = aw_ff;
      ah_in = ah_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FG_COLOR:      fg_in = csr_data;
            CSR_BG_COLOR:      bg_in = csr_data;
            CSR_ACTIVE_WIDTH:  aw_in = csr_data[10:0];
            CSR_ACTIVE_HEIGHT: ah_in = csr_data[9:0];
            default:           fg_in = fg_ff;
         endcase
      end
   end

   // tile grid extent, saturated at the shadow dimensions
   assign w_sum  = 12'(aw_ff) + 12'd7;
   assign w_ceil = w_sum[11:3];
   assign h_sum  = 11'(ah_ff) + 11'd7;
   assign h_ceil = h_sum[10:3];
   assign grid_w = (w_ceil > 9'(MAX_TILE_COLS)) ? 8'(MAX_TILE_COLS) : w_ceil[7:0];
   assign grid_h = (h_ceil > 8'(MAX_TILE_ROWS)) ? 8'(MAX_TILE_ROWS) : h_ceil;

   assign a_in_grid = (req_tile_col < grid_w) && (req_tile_row < grid_h);
   assign a_slot    = 16'(req_tile_row) * 16'(grid_w) + 16'(req_tile_col);

   // visible part of the tile after clipping
   assign rem_w = aw_ff - {req_tile_col, 3'b000};
   assign rem_h = 11'(ah_ff) - {req_tile_row, 3'b000};

   always_comb begin
      a_job.col  = req_tile_col;
      a_job.row  = req_tile_row;
      a_job.bits = {req_column_bits_7, req_column_bits_6, req_column_bits_5,
                    req_column_bits_4, req_column_bits_3, req_column_bits_2,
                    req_column_bits_1, req_column_bits_0};
      a_job.ncm1 = (rem_w >= 11'd8) ? 3'd7 : 3'(rem_w - 11'd1);
      a_job.nrm1 = (rem_h >= 11'd8) ? 3'd7 : 3'(rem_h - 11'd1);
   end

   // compare stage: forward the most recent shadow write
   assign old_bits  = (fwd_valid_ff && (fwd_slot_ff == b_slot_ff)) ? fwd_data_ff
                                                                    : ram_rdata;
   assign b_draw_go = (b_type_ff == REQ_DRAW) && b_in_grid_ff &&
                      !(shadow_ok_ff && (old_bits == b_job_ff.bits));
   assign b_adv     = b_valid_ff && (!b_draw_go || gen_status.ready);

   assign req_stall  = (state_ff != ST_RUN) || (b_valid_ff && !b_adv);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      b_valid_in   = b_valid_ff;
      b_type_in    = b_type_ff;
      b_in_grid_in = b_in_grid_ff;
      b_slot_in    = b_slot_ff;
      b_job_in     = b_job_ff;
      shadow_ok_in = shadow_ok_ff;

      if (b_adv) begin
         b_valid_in = 1'b0;
         case (b_type_ff)
            REQ_REFRESH:    shadow_ok_in = 1'b1;
            REQ_INVALIDATE: shadow_ok_in = 1'b0;
            default:        shadow_ok_in = shadow_ok_ff;
         endcase
      end

      if (req_accept) begin
         b_valid_in   = 1'b1;
         b_type_in    = req_type;
         b_in_grid_in = a_in_grid;
         b_slot_in    = a_in_grid ? a_slot[SLOT_W-1:0] : '0;
         b_job_in     = a_job;
      end
   end

   // clearing pass, then normal operation
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SLOT_W'(1);
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN:  state_in = ST_RUN;
         default: state_in = ST_CLEAR;
      endcase
   end

   // shadow write port: clearing pass or tile update
   always_comb begin
      ram_we       = 1'b0;
      ram_waddr    = b_slot_ff;
      ram_wdata    = b_job_ff.bits;
      fwd_valid_in = fwd_valid_ff;
      fwd_slot_in  = fwd_slot_ff;
      fwd_data_in  = fwd_data_ff;
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else if (b_adv && b_draw_go) begin
         ram_we       = 1'b1;
         fwd_valid_in = 1'b1;
         fwd_slot_in  = b_slot_ff;
         fwd_data_in  = b_job_ff.bits;
      end
   end

   assign ram_raddr = a_in_grid ? a_slot[SLOT_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff        <= FG_COLOR_RST;
         bg_ff        <= BG_COLOR_RST;
         aw_ff        <= ACTIVE_WIDTH_RST;
         ah_ff        <= ACTIVE_HEIGHT_RST;
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         b_valid_ff   <= 1'b0;
         shadow_ok_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         aw_ff        <= aw_in;
         ah_ff        <= ah_in;
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         b_valid_ff   <= b_valid_in;
         shadow_ok_ff <= shadow_ok_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_type_ff    <= b_type_in;
      b_in_grid_ff <= b_in_grid_in;
      b_slot_ff    <= b_slot_in;
      b_job_ff     <= b_job_in;
      fwd_slot_ff  <= fwd_slot_in;
      fwd_data_ff  <= fwd_data_in;
   end

   // tile shadow store
   mtce_ram #(
      .WIDTH (TILE_BITS),
      .DEPTH (DEPTH)
   ) u_shadow (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_accept),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // pixel expansion and result register
   mtce_pixel_gen #(
      .NATIVE_ROW_PIXELS (NATIVE_ROW_PIXELS),
      .LOGICAL_COLS      (LOGICAL_COLS)
   ) u_pixel_gen (
      .clock           (clock),
      .reset           (reset),
      .load_valid      (b_adv && b_draw_go),
      .load_job        (b_job_ff),
      .fg_color        (fg_ff),
      .bg_color        (bg_ff),
      .status          (gen_status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_write  (rsp_last_write)
   );

   // no request work while the shadow is being cleared
   `CHK_IMPLY(a_clear_idle, clock, reset, state_ff == ST_CLEAR,
              !b_valid_ff && !gen_status.busy)
   // a request waiting on the pixel generator keeps its slot
   `CHK_NEXT(a_b_hold, clock, reset, b_valid_ff && !b_adv,
             b_valid_ff && $stable(b_slot_ff))
   // after the clearing pass only a tile update writes the shadow
   `CHK_IMPLY(a_wr_src, clock, reset, ram_we && state_ff == ST_RUN,
              b_valid_ff && b_draw_go)

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the mono tile color expander: tile draws, shadow reuse, clipping.
`timescale 1ns / 100ps

module tb_top;
   import mtce_pkg::*;

   localparam int MAX_TILE_COLS     = 160;
   localparam int MAX_TILE_ROWS     = 90;
   localparam int NATIVE_ROW_PIXELS = 720;
   localparam int LOGICAL_COLS      = 1280;
   localparam int SHADOW_SLOTS      = MAX_TILE_COLS * MAX_TILE_ROWS;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // logical pixel (0,0) lands at the start of the last native row
   localparam logic [19:0] TOP_LEFT_INDEX = 20'((LOGICAL_COLS - 1) * NATIVE_ROW_PIXELS);

   localparam int SETTLE_CYCLES   = 8;
   localparam int STUCK_LIMIT     = 50000;
   localparam int PHASE_COUNT     = 5;
   localparam int ITEMS_PER_PHASE = 35;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [63:0] bits;   // byte n is pixel column n
   } tile_req_type;

   typedef struct packed {
      logic [19:0] index;
      logic [15:0] color;
      logic        last;
   } pix_write_type;

   typedef struct {
      bit           is_csr;
      logic [1:0]   reg_sel;
      logic [15:0]  reg_val;
      tile_req_type req;
      int           typed_n;      // -1: take the writes from the tile model
      logic [19:0]  typed_index;
      logic [15:0]  typed_color;
   } dir_row_type;

   // DUT connections, all driven from time zero
   logic        clock;
   logic        reset             = 1'b1;
   logic        csr_valid         = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index         = '0;
   logic [15:0] csr_data          = '0;
   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type          = '0;
   logic [7:0]  req_tile_col      = '0;
   logic [7:0]  req_tile_row      = '0;
   logic [7:0]  req_column_bits_0 = '0;
   logic [7:0]  req_column_bits_1 = '0;
   logic [7:0]  req_column_bits_2 = '0;
   logic [7:0]  req_column_bits_3 = '0;
   logic [7:0]  req_column_bits_4 = '0;
   logic [7:0]  req_column_bits_5 = '0;
   logic [7:0]  req_column_bits_6 = '0;
   logic [7:0]  req_column_bits_7 = '0;
   logic        rsp_valid;
   logic        rsp_stall         = 1'b0;
   logic [PIX_IDX_W-1:0] rsp_pixel_index;
   logic [15:0] rsp_pixel_color;
   logic        rsp_last_write;

   mono_tile_color_expander i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_tile_col      (req_tile_col),
      .req_tile_row      (req_tile_row),
      .req_column_bits_0 (req_column_bits_0),
      .req_column_bits_1 (req_column_bits_1),
      .req_column_bits_2 (req_column_bits_2),
      .req_column_bits_3 (req_column_bits_3),
      .req_column_bits_4 (req_column_bits_4),
      .req_column_bits_5 (req_column_bits_5),
      .req_column_bits_6 (req_column_bits_6),
      .req_column_bits_7 (req_column_bits_7),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_index   (rsp_pixel_index),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_write    (rsp_last_write)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // tile model state: registers, shadow store (cleared), shadow-valid mark
   logic [15:0] cfg_fg     = FG_COLOR_RST;
   logic [15:0] cfg_bg     = BG_COLOR_RST;
   logic [10:0] cfg_width  = ACTIVE_WIDTH_RST;
   logic [9:0]  cfg_height = ACTIVE_HEIGHT_RST;
   bit [63:0]   shadow_tiles [SHADOW_SLOTS];
   bit          shadow_armed = 1'b0;

   pix_write_type pending_writes [$];
   dir_row_type   dir_rows [$];
   pix_write_type due_write;

   int fail_count     = 0;
   int reqs_accepted  = 0;
   int draws_accepted = 0;
   int writes_checked = 0;
   int regs_written   = 0;
   int shadow_drops   = 0;
   int burst_left     = 1;
   int stuck_cycles   = 0;
   int stall_mode     = 0;
   int stall_left     = 0;
   int stall_tick     = 0;

   // tiles per axis: ceiling over eight, saturated at the store's extent
   function automatic int grid_span(input int unsigned pixels, input int unsigned cap);
      int unsigned tiles;
      tiles = (pixels + 7) / 8;
      return (tiles > cap) ? cap : tiles;
   endfunction

   // expected pixel writes of one request; updates shadow and mark
   function automatic void expand_tile(input tile_req_type r, ref pix_write_type writes[$]);
      int unsigned   gw, gh, slot, lx, ly;
      pix_write_type w;
      writes.delete();
      if (r.kind == REQ_REFRESH) begin
         shadow_armed = 1'b1;
         return;
      end
      if (r.kind == REQ_INVALIDATE) begin
         shadow_armed = 1'b0;
         return;
      end
      if (r.kind != REQ_DRAW) return;
      gw = grid_span(cfg_width, MAX_TILE_COLS);
      gh = grid_span(cfg_height, MAX_TILE_ROWS);
      if (r.col >= gw || r.row >= gh) return;
      slot = r.row * gw + r.col;
      if (slot >= SHADOW_SLOTS) return;
      if (shadow_armed && shadow_tiles[slot] == r.bits) begin
         shadow_drops++;
         return;
      end
      shadow_tiles[slot] = r.bits;
      // columns outer, rows inner, clipped to the active area
      for (int px = 0; px < 8; px++) begin
         lx = r.col * 8 + px;
         if (lx >= cfg_width) break;
         for (int py = 0; py < 8; py++) begin
            ly = r.row * 8 + py;
            if (ly >= cfg_height) break;
            w.index = 20'((LOGICAL_COLS - 1 - lx) * NATIVE_ROW_PIXELS + ly);
            w.color = r.bits[8 * px + py] ? cfg_fg : cfg_bg;
            w.last  = 1'b0;
            writes.push_back(w);
         end
      end
      if (writes.size() > 0) writes[writes.size() - 1].last = 1'b1;
   endfunction

   function automatic void add_req(input logic [1:0] kind, input logic [7:0] col,
                                   input logic [7:0] row, input logic [63:0] bits,
                                   input int typed_n, input logic [19:0] t_index = '0,
                                   input logic [15:0] t_color = '0);
      dir_row_type d;
      d.is_csr      = 1'b0;
      d.reg_sel     = CSR_FG_COLOR;
      d.reg_val     = '0;
      d.req         = '{kind, col, row, bits};
      d.typed_n     = typed_n;
      d.typed_index = t_index;
      d.typed_color = t_color;
      dir_rows.push_back(d);
   endfunction

   function automatic void add_reg(input logic [1:0] sel, input logic [15:0] val);
      dir_row_type d;
      d.is_csr      = 1'b1;
      d.reg_sel     = sel;
      d.reg_val     = val;
      d.req         = '0;
      d.typed_n     = 0;
      d.typed_index = '0;
      d.typed_color = '0;
      dir_rows.push_back(d);
   endfunction

   // present one request, hold it until taken, then record its writes
   task automatic push_req(input tile_req_type r, input int typed_n = -1,
                           input logic [19:0] t_index = '0, input logic [15:0] t_color = '0);
      pix_write_type fresh [$];
      pix_write_type w;
      int            gap;
      req_valid         <= 1'b1;
      req_type          <= r.kind;
      req_tile_col      <= r.col;
      req_tile_row      <= r.row;
      req_column_bits_0 <= r.bits[7:0];
      req_column_bits_1 <= r.bits[15:8];
      req_column_bits_2 <= r.bits[23:16];
      req_column_bits_3 <= r.bits[31:24];
      req_column_bits_4 <= r.bits[39:32];
      req_column_bits_5 <= r.bits[47:40];
      req_column_bits_6 <= r.bits[55:48];
      req_column_bits_7 <= r.bits[63:56];
      do @(posedge clock); while (!(req_valid && !req_stall));
      expand_tile(r, fresh);
      if (typed_n >= 0) begin
         fresh.delete();
         if (typed_n > 0) begin
            w = '{t_index, t_color, 1'b1};
            fresh.push_back(w);
         end
      end
      foreach (fresh[i]) pending_writes.push_back(fresh[i]);
      reqs_accepted++;
      if (r.kind == REQ_DRAW) draws_accepted++;
      // bursts of back-to-back requests, random gap after each
      if (burst_left > 1) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // let every expected write arrive, then allow dropped tiles to clear the pipe
   task automatic drain_writes();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] sel, input logic [15:0] val, input bit keep_valid);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      if (!keep_valid) csr_valid <= 1'b0;
      case (sel)
         CSR_FG_COLOR:      cfg_fg = val;
         CSR_BG_COLOR:      cfg_bg = val;
         CSR_ACTIVE_WIDTH:  cfg_width = val[10:0];
         CSR_ACTIVE_HEIGHT: cfg_height = val[9:0];
         default: ;
      endcase
      regs_written++;
   endtask

   // receiver stall: free-running, random, or periodic stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(16, 160);
      end else begin
         stall_left = stall_left - 1;
      end
      stall_tick = stall_tick + 1;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 2) == 0);
         default: rsp_stall <= ((stall_tick % 12) < 5);
      endcase
   end

   // compare each taken pixel write with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            $error("pixel write to index %0d with no write expected", rsp_pixel_index);
            fail_count++;
         end else begin
            due_write = pending_writes.pop_front();
            if (rsp_pixel_index !== due_write.index) begin
               $error("pixel_index: expected %0d, got %0d", due_write.index, rsp_pixel_index);
               fail_count++;
            end
            if (rsp_pixel_color !== due_write.color) begin
               $error("pixel_color: expected 0x%04h, got 0x%04h", due_write.color,
                      rsp_pixel_color);
               fail_count++;
            end
            if (rsp_last_write !== due_write.last) begin
               $error("last_write: expected %0b, got %0b", due_write.last, rsp_last_write);
               fail_count++;
            end
         end
         writes_checked++;
      end
   end

   // watchdog: abort when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d writes outstanding",
                     stuck_cycles, pending_writes.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin : run_seq
      tile_req_type r;
      tile_req_type recent [$];
      int           gw, gh, roll, counted;
      bit           count_it;
      logic [15:0]  ph_fg, ph_bg;
      logic [10:0]  ph_w;
      logic [9:0]   ph_h;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: defaults, grid edges, shadow reuse, 1x1 and partial clipping
      add_req(REQ_DRAW, 8'd0, 8'd0, '1, -1);
      add_req(REQ_DRAW, 8'd159, 8'd89, 64'h8040_2010_0804_0201, -1);
      add_req(REQ_DRAW, 8'd160, 8'd0, 64'h1234_5678_9abc_def0, 0);
      add_req(REQ_DRAW, 8'd0, 8'd90, '1, 0);
      add_req(REQ_DRAW, 8'd255, 8'd255, '1, 0);
      add_req(REQ_UNUSED, 8'd255, 8'd255, '1, 0);
      add_req(REQ_REFRESH, 8'd0, 8'd0, '0, 0);
      add_req(REQ_DRAW, 8'd0, 8'd0, '1, 0);                 // same tile, shadow valid
      add_req(REQ_DRAW, 8'd0, 8'd0, '0, -1);
      add_req(REQ_INVALIDATE, 8'd0, 8'd0, '0, 0);
      add_req(REQ_DRAW, 8'd0, 8'd0, '0, -1);                // same tile, shadow invalid
      add_reg(CSR_FG_COLOR, 16'h0000);
      add_reg(CSR_BG_COLOR, 16'hffff);
      add_reg(CSR_ACTIVE_WIDTH, 16'd1);
      add_reg(CSR_ACTIVE_HEIGHT, 16'd1);
      add_req(REQ_DRAW, 8'd0, 8'd0, 64'h1, 1, TOP_LEFT_INDEX, 16'h0000);
      add_req(REQ_DRAW, 8'd0, 8'd0, 64'hffff_ffff_ffff_fffe, 1, TOP_LEFT_INDEX, 16'hffff);
      add_req(REQ_DRAW, 8'd1, 8'd0, '1, 0);
      add_req(REQ_DRAW, 8'd0, 8'd1, '1, 0);
      add_reg(CSR_ACTIVE_WIDTH, 16'd13);
      add_reg(CSR_ACTIVE_HEIGHT, 16'd11);
      add_reg(CSR_FG_COLOR, 16'hf81f);
      add_req(REQ_DRAW, 8'd1, 8'd1, 64'ha55a_3cc3_0ff0_f00f, -1);
      add_req(REQ_REFRESH, 8'd0, 8'd0, '0, 0);
      add_req(REQ_DRAW, 8'd1, 8'd1, 64'ha55a_3cc3_0ff0_f00f, 0);
      add_req(REQ_DRAW, 8'd2, 8'd1, '1, 0);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) begin
            drain_writes();
            write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val, 1'b0);
         end else begin
            push_req(dir_rows[i].req, dir_rows[i].typed_n, dir_rows[i].typed_index,
                     dir_rows[i].typed_color);
         end
      end

      // random phases, each under its own register setting
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         ph_fg = 16'($urandom_range(0, 65535));
         ph_bg = 16'($urandom_range(0, 65535));
         case (phase)
            0: begin
               ph_w = 11'd1280;
               ph_h = 10'd720;
            end
            1: begin
               ph_w = 11'($urandom_range(1, 48));
               ph_h = 10'($urandom_range(1, 40));
            end
            2: begin
               ph_w = 11'd1;
               ph_h = 10'd720;
            end
            3: begin
               ph_w = 11'($urandom_range(1, 1280));
               ph_h = 10'($urandom_range(1, 720));
            end
            default: begin
               ph_w  = 11'd1280;
               ph_h  = 10'd1;
               ph_fg = 16'hffff;
               ph_bg = 16'h0000;
            end
         endcase
         drain_writes();
         write_reg(CSR_FG_COLOR, ph_fg, 1'b1);
         write_reg(CSR_BG_COLOR, ph_bg, 1'b1);
         write_reg(CSR_ACTIVE_WIDTH, {5'd0, ph_w}, 1'b1);
         write_reg(CSR_ACTIVE_HEIGHT, {6'd0, ph_h}, 1'b0);
         recent.delete();
         counted = 0;
         gw = grid_span(cfg_width, MAX_TILE_COLS);
         gh = grid_span(cfg_height, MAX_TILE_ROWS);

         while (counted < ITEMS_PER_PHASE) begin
            roll     = $urandom_range(0, 99);
            r.col    = 8'($urandom_range(0, 255));
            r.row    = 8'($urandom_range(0, 255));
            r.bits   = {$urandom, $urandom};
            count_it = 1'b1;
            if (roll < 10) begin
               r.kind = REQ_REFRESH;
            end else if (roll < 16) begin
               r.kind = REQ_INVALIDATE;
            end else if (roll < 20) begin
               r.kind   = REQ_UNUSED;
               count_it = 1'b0;
            end else if (roll < 28) begin
               // off the tile grid, silently dropped
               r.kind   = REQ_DRAW;
               count_it = 1'b0;
               if ($urandom_range(0, 1)) r.col = 8'($urandom_range(gw, 255));
               else r.row = 8'($urandom_range(gh, 255));
            end else begin
               // partly redraws of recent tiles so the shadow compare gets hits
               r.kind = REQ_DRAW;
               if (recent.size() != 0 && roll < 60) begin
                  r = recent[$urandom_range(0, recent.size() - 1)];
                  if (roll < 36) r.bits = r.bits ^ (64'd1 << $urandom_range(0, 63));
               end else begin
                  r.col = 8'(($urandom_range(0, 3) != 0) ?
                          $urandom_range(0, (gw > 4) ? 3 : gw - 1) : $urandom_range(0, gw - 1));
                  r.row = 8'(($urandom_range(0, 3) != 0) ?
                          $urandom_range(0, (gh > 4) ? 3 : gh - 1) : $urandom_range(0, gh - 1));
               end
               recent.push_back(r);
               if (recent.size() > 8) void'(recent.pop_front());
            end
            push_req(r);
            if (count_it) counted++;
         end
      end

      drain_writes();
      $display("Run: %0d requests (%0d tile draws, %0d dropped as unchanged), %0d csr writes.",
               reqs_accepted, draws_accepted, shadow_drops, regs_written);
      $display("Run: %0d pixel writes checked, %0d mismatches.", writes_checked, fail_count);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
